// ----- rtl/fdtd_ps_pkg.sv -----
// Shared types, constants and the pitch table for the finite-difference plucked string.
// Used by every module of the block but the divider; depends on nothing else.
package fdtd_ps_pkg;

  // Default number of string segments (points 0 .. STRING_SEGMENTS, ends fixed).
  localparam int STRING_SEGMENTS_DEF = 64;

  // Field widths.
  localparam int ACTION_W   = 2;
  localparam int NOTE_W     = 7;
  localparam int AMP_W      = 32;
  localparam int BASE_W     = 18;
  localparam int PICK_W     = 6;
  localparam int HEIGHT_W   = 30;
  localparam int VOL_W      = 18;
  localparam int ROM_W      = 17;
  localparam int CS_W       = 28;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  // Pitch split: d = note + 3, k = d / 6, r = d % 6, courant = (base * rom[r]) >> (28 - k).
  localparam int NOTE_OFFSET    = 3;
  localparam int PITCH_DIV      = 6;
  localparam int PITCH_RECIP    = 43;
  localparam int PITCH_RECIP_SH = 8;
  localparam int PITCH_SHIFT    = 28;
  localparam int PITCH_K_W      = 5;
  localparam int PITCH_R_W      = 3;

  // Actions carried in the input tuser.
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 2'd3;

  // Register reset values.
  localparam logic [BASE_W-1:0]   COURANT_BASE_RST = 18'd4096;
  localparam logic [PICK_W-1:0]   PICK_RST         = 6'd31;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST       = 30'd268435456;
  localparam logic [VOL_W-1:0]    VOLUME_RST       = 18'd65536;

  typedef struct packed {
    logic [BASE_W-1:0]   courant_base_sq;
    logic [PICK_W-1:0]   pick_index;
    logic [HEIGHT_W-1:0] pluck_height;
    logic [VOL_W-1:0]    volume;
  } cfg_t;

  // Work handed to the string engine when an item is taken.
  typedef struct packed {
    logic              pluck;
    logic              tick;
    logic              update;
    logic [NOTE_W-1:0] note_id;
  } cmd_t;

  typedef struct packed {
    logic                    valid;
    logic signed [AMP_W-1:0] sample;
    logic                    note_held;
  } res_t;

  // round(2^(r/6) * 65536) for r = 0 .. 5.
  function automatic logic [ROM_W-1:0] pitch_rom(input logic [PITCH_R_W-1:0] r);
    logic [ROM_W-1:0] v;
    case (r)
      3'd0:    v = 17'd65536;
      3'd1:    v = 17'd73562;
      3'd2:    v = 17'd82570;
      3'd3:    v = 17'd92682;
      3'd4:    v = 17'd104032;
      3'd5:    v = 17'd116772;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to the 32-bit amplitude range.
  function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [63:0] v);
    logic signed [AMP_W-1:0] s;
    if ((&v[63:AMP_W-1]) || !(|v[63:AMP_W-1])) begin
      s = v[AMP_W-1:0];
    end else if (v[63]) begin
      s = {1'b1, {(AMP_W-1){1'b0}}};
    end else begin
      s = {1'b0, {(AMP_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ----- rtl/fdtd_ps_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, for the pluck slopes.
// Uses no package items; instantiated by fdtd_ps_core.
module fdtd_ps_divider #(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // The partial remainder never exceeds the divisor, so one guard bit suffices.
  assign rem_sh = {rem, quo[DIVIDEND_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- rtl/fdtd_ps_amp_mem.sv -----
// String state memories: present and previous amplitude of every point.
// One write port and one registered read port each; uses fdtd_ps_pkg for widths.
module fdtd_ps_amp_mem #(
  parameter int STRING_SEGMENTS = fdtd_ps_pkg::STRING_SEGMENTS_DEF
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(STRING_SEGMENTS)-1:0]       waddr,
  input  logic signed [fdtd_ps_pkg::AMP_W-1:0]     wdata_now,
  input  logic signed [fdtd_ps_pkg::AMP_W-1:0]     wdata_prev,
  input  logic [$clog2(STRING_SEGMENTS)-1:0]       raddr_now,
  input  logic [$clog2(STRING_SEGMENTS)-1:0]       raddr_prev,
  output logic signed [fdtd_ps_pkg::AMP_W-1:0]     rdata_now,
  output logic signed [fdtd_ps_pkg::AMP_W-1:0]     rdata_prev
);

  logic signed [fdtd_ps_pkg::AMP_W-1:0] now_mem  [STRING_SEGMENTS];
  logic signed [fdtd_ps_pkg::AMP_W-1:0] prev_mem [STRING_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      now_mem[waddr]  <= wdata_now;
      prev_mem[waddr] <= wdata_prev;
    end
    rdata_now  <= now_mem[raddr_now];
    rdata_prev <= prev_mem[raddr_prev];
  end

endmodule

// ----- rtl/fdtd_ps_core.sv -----
// String engine: pitch scaling, pluck sweep with a shared serial divider, and the
// pipelined wave-equation sweep. Uses fdtd_ps_pkg, fdtd_ps_divider and fdtd_ps_amp_mem.
module fdtd_ps_core #(
  parameter int STRING_SEGMENTS = fdtd_ps_pkg::STRING_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fdtd_ps_pkg::cfg_t  cfg,
  input  fdtd_ps_pkg::cmd_t  cmd,
  output logic               idle,
  output fdtd_ps_pkg::res_t  res,
  input  logic               res_take
);

  localparam int AW      = $clog2(STRING_SEGMENTS);
  localparam int CW      = (AW > fdtd_ps_pkg::PICK_W) ? AW : fdtd_ps_pkg::PICK_W;
  localparam int AMP_W   = fdtd_ps_pkg::AMP_W;
  localparam int HW      = fdtd_ps_pkg::HEIGHT_W;
  localparam int LAP_W   = AMP_W + 2;
  localparam int MUL_W   = fdtd_ps_pkg::CS_W + 1 + LAP_W;
  localparam int TERM_W  = MUL_W - fdtd_ps_pkg::FRAC_W;
  localparam int SUM_W   = TERM_W + 1;
  localparam int OPROD_W = fdtd_ps_pkg::VOL_W + 1 + AMP_W;
  localparam int PPROD_W = fdtd_ps_pkg::BASE_W + fdtd_ps_pkg::ROM_W;
  localparam int D_W     = fdtd_ps_pkg::NOTE_W + 1;
  localparam int KP_W    = D_W + 6;
  localparam int KW      = fdtd_ps_pkg::PITCH_K_W;
  localparam int RW      = fdtd_ps_pkg::PITCH_R_W;
  localparam logic [AW-1:0] X_LAST = AW'(STRING_SEGMENTS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PITCH  = 4'd1;
  localparam logic [3:0] S_SCALE  = 4'd2;
  localparam logic [3:0] S_DIVA   = 4'd3;
  localparam logic [3:0] S_DIVB   = 4'd4;
  localparam logic [3:0] S_PLUCK  = 4'd5;
  localparam logic [3:0] S_TISSUE = 4'd6;
  localparam logic [3:0] S_TDRAIN = 4'd7;
  localparam logic [3:0] S_OMUL   = 4'd8;
  localparam logic [3:0] S_OSAT   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;

  // Pitch.
  logic [D_W-1:0]                  note_d;
  logic [KP_W-1:0]                 k_prod;
  logic [KW-1:0]                   k_est;
  logic [D_W-1:0]                  r_full;
  logic [KW-1:0]                   k_fix;
  logic [RW-1:0]                   r_fix;
  logic [KW-1:0]                   pk;
  logic [RW-1:0]                   pr;
  logic [PPROD_W-1:0]              pitch_prod;
  logic [KW-1:0]                   shamt;
  logic [fdtd_ps_pkg::CS_W-1:0]    courant_sq;

  // Pick point and slopes.
  logic [CW-1:0] pick_w;
  logic [CW-1:0] pick_lim;
  logic [CW-1:0] pick_c;
  logic [AW-1:0] pick;
  logic [AW-1:0] tail;

  logic          div_start;
  logic          div_done;
  logic [AW-1:0] div_divisor;
  logic [HW-1:0] div_q;
  logic [AW-1:0] div_r;
  logic [HW-1:0] q1;
  logic [HW-1:0] q2;
  logic [AW-1:0] r1;
  logic [AW-1:0] r2;

  // Pluck sweep.
  logic [AW-1:0] x;
  logic [AW-1:0] x_inc;
  logic [HW-1:0] acc_q;
  logic [AW-1:0] acc_r;
  logic          in_first;
  logic [HW-1:0] q_sel;
  logic [AW-1:0] r_sel;
  logic [AW-1:0] d_sel;
  logic [AW:0]   sum_r;
  logic          wraps;
  logic [HW-1:0] pluck_val;

  // Tick sweep pipeline.
  logic [AW-1:0]               ix;
  logic                        v1;
  logic                        v2;
  logic                        v3;
  logic                        prime1;
  logic                        last1;
  logic [AW-1:0]               x1;
  logic [AW-1:0]               x2;
  logic [AW-1:0]               x3;
  logic signed [AMP_W-1:0]     left;
  logic signed [AMP_W-1:0]     mid;
  logic signed [AMP_W-1:0]     right_v;
  logic signed [LAP_W-1:0]     lap_next;
  logic signed [LAP_W-1:0]     base_next;
  logic signed [LAP_W-1:0]     lap2;
  logic signed [LAP_W-1:0]     base2;
  logic signed [LAP_W-1:0]     base3;
  logic signed [AMP_W-1:0]     old2;
  logic signed [AMP_W-1:0]     old3;
  logic signed [MUL_W-1:0]     prod3;
  logic signed [TERM_W-1:0]    term;
  logic signed [SUM_W-1:0]     sum_amp;
  logic signed [AMP_W-1:0]     new_amp;
  logic signed [AMP_W-1:0]     pick_amp;
  logic signed [OPROD_W-1:0]   out_prod;
  logic signed [AMP_W-1:0]     res_sample;
  logic                        res_held;

  // Memory ports.
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [AMP_W-1:0] mem_wdata_now;
  logic signed [AMP_W-1:0] mem_wdata_prev;
  logic [AW-1:0]           mem_raddr_now;
  logic [AW-1:0]           mem_raddr_prev;
  logic signed [AMP_W-1:0] rd_now;
  logic signed [AMP_W-1:0] rd_prev;

  // Note split into octave pair index and step, by reciprocal and one correction.
  always_comb begin
    note_d = D_W'(cmd.note_id) + D_W'(fdtd_ps_pkg::NOTE_OFFSET);
    k_prod = KP_W'(note_d) * KP_W'(fdtd_ps_pkg::PITCH_RECIP);
    k_est  = k_prod[fdtd_ps_pkg::PITCH_RECIP_SH +: KW];
    r_full = note_d - (D_W'(k_est) * D_W'(fdtd_ps_pkg::PITCH_DIV));
    if (r_full >= D_W'(fdtd_ps_pkg::PITCH_DIV)) begin
      k_fix = k_est + 1'b1;
      r_fix = RW'(r_full - D_W'(fdtd_ps_pkg::PITCH_DIV));
    end else begin
      k_fix = k_est;
      r_fix = RW'(r_full);
    end
  end

  assign shamt = KW'(fdtd_ps_pkg::PITCH_SHIFT) - pk;

  // Pick point held inside 1 .. STRING_SEGMENTS-2.
  always_comb begin
    pick_w   = CW'(cfg.pick_index);
    pick_lim = CW'(STRING_SEGMENTS - 2);
    if (pick_w == '0) begin
      pick_c = CW'(1);
    end else if (pick_w > pick_lim) begin
      pick_c = pick_lim;
    end else begin
      pick_c = pick_w;
    end
  end

  assign pick = pick_c[AW-1:0];
  assign tail = X_LAST - pick;

  assign div_start   = (state == S_SCALE) || (state == S_DIVA && div_done);
  assign div_divisor = (state == S_SCALE) ? pick : tail;

  fdtd_ps_divider #(
    .DIVIDEND_W (HW),
    .DIVISOR_W  (AW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cfg.pluck_height),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Triangle points come from running quotient and remainder of h*x/p and h*(x-p)/tail.
  always_comb begin
    in_first  = x < pick;
    x_inc     = x + 1'b1;
    q_sel     = in_first ? q1 : q2;
    r_sel     = in_first ? r1 : r2;
    d_sel     = in_first ? pick : tail;
    sum_r     = (AW + 1)'(acc_r) + (AW + 1)'(r_sel);
    wraps     = sum_r >= (AW + 1)'(d_sel);
    pluck_val = in_first ? acc_q : cfg.pluck_height - acc_q;
  end

  // Update stage one: window of three neighbours plus the previous value.
  always_comb begin
    right_v   = last1 ? '0 : rd_now;
    lap_next  = LAP_W'(left) - (LAP_W'(mid) <<< 1) + LAP_W'(right_v);
    base_next = (LAP_W'(mid) <<< 1) - LAP_W'(rd_prev);
  end

  // Update stage three: floor shift of the product, add and saturate.
  always_comb begin
    term    = $signed(prod3[MUL_W-1:fdtd_ps_pkg::FRAC_W]);
    sum_amp = SUM_W'(base3) + SUM_W'(term);
    new_amp = fdtd_ps_pkg::sat_amp(64'(sum_amp));
  end

  always_comb begin
    mem_we         = (state == S_PLUCK) || v3;
    mem_waddr      = (state == S_PLUCK) ? x : x3;
    mem_wdata_now  = (state == S_PLUCK) ? AMP_W'(pluck_val) : new_amp;
    mem_wdata_prev = (state == S_PLUCK) ? AMP_W'(pluck_val) : old3;
    mem_raddr_now  = (ix == X_LAST) ? '0 : ix + 1'b1;
    mem_raddr_prev = ix;
  end

  fdtd_ps_amp_mem #(
    .STRING_SEGMENTS (STRING_SEGMENTS)
  ) u_mem (
    .clk        (clk),
    .we         (mem_we),
    .waddr      (mem_waddr),
    .wdata_now  (mem_wdata_now),
    .wdata_prev (mem_wdata_prev),
    .raddr_now  (mem_raddr_now),
    .raddr_prev (mem_raddr_prev),
    .rdata_now  (rd_now),
    .rdata_prev (rd_prev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      courant_sq <= '0;
    end else begin
      v1 <= (state == S_TISSUE);
      v2 <= v1 && !prime1;
      v3 <= v2;
      case (state)
        S_IDLE: begin
          if (cmd.pluck) begin
            state <= S_PITCH;
          end else if (cmd.tick) begin
            state <= cmd.update ? S_TISSUE : S_DONE;
          end
        end
        S_PITCH: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          courant_sq <= fdtd_ps_pkg::CS_W'(pitch_prod >> shamt);
          state      <= S_DIVA;
        end
        S_DIVA: begin
          if (div_done) begin
            state <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            state <= S_PLUCK;
          end
        end
        S_PLUCK: begin
          if (x == X_LAST) begin
            state <= S_IDLE;
          end
        end
        S_TISSUE: begin
          if (ix == X_LAST) begin
            state <= S_TDRAIN;
          end
        end
        S_TDRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= S_OMUL;
          end
        end
        S_OMUL: begin
          state <= S_OSAT;
        end
        S_OSAT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.pluck) begin
      pk <= k_fix;
      pr <= r_fix;
    end
    if (state == S_IDLE && cmd.tick) begin
      res_held   <= cmd.update;
      res_sample <= '0;
      ix         <= '0;
    end
    if (state == S_PITCH) begin
      pitch_prod <= cfg.courant_base_sq * fdtd_ps_pkg::pitch_rom(pr);
    end
    if (state == S_DIVA && div_done) begin
      q1 <= div_q;
      r1 <= div_r;
    end
    if (state == S_DIVB && div_done) begin
      q2    <= div_q;
      r2    <= div_r;
      x     <= '0;
      acc_q <= '0;
      acc_r <= '0;
    end
    if (state == S_PLUCK) begin
      x <= x_inc;
      if (x_inc == pick) begin
        // The falling slope restarts from the peak.
        acc_q <= '0;
        acc_r <= '0;
      end else if (wraps) begin
        acc_q <= acc_q + q_sel + 1'b1;
        acc_r <= AW'(sum_r - (AW + 1)'(d_sel));
      end else begin
        acc_q <= acc_q + q_sel;
        acc_r <= AW'(sum_r);
      end
    end
    if (state == S_TISSUE) begin
      ix     <= ix + 1'b1;
      x1     <= ix;
      prime1 <= (ix == '0);
      last1  <= (ix == X_LAST);
    end
    if (v1) begin
      if (prime1) begin
        // Point zero is a fixed end and stays zero.
        left <= '0;
        mid  <= rd_now;
      end else begin
        lap2  <= lap_next;
        base2 <= base_next;
        old2  <= mid;
        x2    <= x1;
        left  <= mid;
        mid   <= right_v;
      end
    end
    if (v2) begin
      prod3 <= $signed({1'b0, courant_sq}) * lap2;
      base3 <= base2;
      old3  <= old2;
      x3    <= x2;
    end
    if (v3 && x3 == pick) begin
      pick_amp <= new_amp;
    end
    if (state == S_OMUL) begin
      out_prod <= $signed({1'b0, cfg.volume}) * pick_amp;
    end
    if (state == S_OSAT) begin
      res_sample <= fdtd_ps_pkg::sat_amp(
                      64'($signed(out_prod[OPROD_W-1:fdtd_ps_pkg::FRAC_W])));
    end
  end

  assign idle          = (state == S_IDLE);
  assign res.valid     = (state == S_DONE);
  assign res.sample    = res_sample;
  assign res.note_held = res_held;

endmodule

// ----- rtl/fdtd_plucked_string_top.sv -----
// Sample tick with a note held: the single update multiplier walks the amplitude memories
// one point a cycle. Note-on with no note held: two 30-step serial divisions and a
// write sweep. Other actions and a tick with no note run neither sweep.
// One item at a time; a result in the output register does not block the next transfer.
// Reset (synchronous, active high) restores the registers and drops the note.
module fdtd_plucked_string_top #(
  parameter int STRING_SEGMENTS = fdtd_ps_pkg::STRING_SEGMENTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,   // [6:0] note_id
  input  logic [fdtd_ps_pkg::ACTION_W-1:0]      s_tuser,   // [1:0] action
  // Output stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [fdtd_ps_pkg::AMP_W-1:0]         m_tdata,   // [31:0] sample
  output logic                                  m_tuser,   // [0] note_held
  // Configuration writes.
  input  logic                                  cfg_we,
  input  logic [fdtd_ps_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fdtd_ps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  fdtd_ps_pkg::cfg_t cfg;
  fdtd_ps_pkg::cmd_t cmd;
  fdtd_ps_pkg::res_t res;

  logic                           core_idle;
  logic                           in_xfer;
  logic                           res_take;
  logic [fdtd_ps_pkg::NOTE_W-1:0] note_id;
  logic                           held;
  logic                           released;
  logic [fdtd_ps_pkg::NOTE_W-1:0] held_note;

  // The amplitude memories are not cleared at reset. Nothing reads them until the
  // first note-on, and that note-on rewrites every point with the pluck shape.

  assign note_id  = s_tdata[fdtd_ps_pkg::NOTE_W-1:0];
  assign s_tready = core_idle;
  assign in_xfer  = s_tvalid && s_tready;

  // Only a tick, or a note-on that finds the string at rest, needs the engine.
  always_comb begin
    cmd.note_id = note_id;
    cmd.update  = held;
    cmd.tick    = in_xfer && (s_tuser == fdtd_ps_pkg::ACT_TICK);
    cmd.pluck   = in_xfer && (s_tuser == fdtd_ps_pkg::ACT_NOTE_ON) && !held;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.courant_base_sq <= fdtd_ps_pkg::COURANT_BASE_RST;
      cfg.pick_index      <= fdtd_ps_pkg::PICK_RST;
      cfg.pluck_height    <= fdtd_ps_pkg::HEIGHT_RST;
      cfg.volume          <= fdtd_ps_pkg::VOLUME_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        fdtd_ps_pkg::REG_COURANT_BASE: begin
          cfg.courant_base_sq <= fdtd_ps_pkg::BASE_W'(cfg_wdata);
        end
        fdtd_ps_pkg::REG_PICK: begin
          cfg.pick_index <= fdtd_ps_pkg::PICK_W'(cfg_wdata);
        end
        fdtd_ps_pkg::REG_HEIGHT: begin
          cfg.pluck_height <= fdtd_ps_pkg::HEIGHT_W'(cfg_wdata);
        end
        fdtd_ps_pkg::REG_VOLUME: begin
          cfg.volume <= fdtd_ps_pkg::VOL_W'(cfg_wdata);
        end
        default: begin
        end
      endcase
    end
  end

  // Note bookkeeping. A released note still sounds for the tick that follows the
  // release, so the flags drop on that tick's transfer while the engine is told
  // that the note was held.
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      released  <= 1'b0;
      held_note <= '0;
    end else if (in_xfer) begin
      case (s_tuser)
        fdtd_ps_pkg::ACT_TICK: begin
          if (held && released) begin
            held     <= 1'b0;
            released <= 1'b0;
          end
        end
        fdtd_ps_pkg::ACT_NOTE_ON: begin
          if (held) begin
            // Same note again keeps it sounding; another note only relabels it.
            if (note_id == held_note) begin
              released <= 1'b0;
            end else begin
              held_note <= note_id;
            end
          end else begin
            held      <= 1'b1;
            released  <= 1'b0;
            held_note <= note_id;
          end
        end
        fdtd_ps_pkg::ACT_NOTE_OFF: begin
          if (held && note_id == held_note) begin
            released <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  fdtd_ps_core #(
    .STRING_SEGMENTS (STRING_SEGMENTS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .idle     (core_idle),
    .res      (res),
    .res_take (res_take)
  );

  // Output register: the engine hands over its result whenever the register is
  // free or being emptied in the same cycle, and then returns to idle.
  assign res_take = res.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= res.sample;
      m_tuser <= res.note_held;
    end
  end

endmodule

// ----- tb/sv/tb_fdtd_plucked_string_top.sv -----
// Self-checking bench for the finite-difference plucked string: note events go in as
// stream transfers and a behavioural string in the bench predicts every tick's sample.
// Depends on fdtd_ps_pkg and fdtd_plucked_string_top only.
module tb_fdtd_plucked_string_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGMENTS = fdtd_ps_pkg::STRING_SEGMENTS_DEF;

  // A note-on sweep yields no result, so before a register write (and at the end) we
  // allow for two such sweeps once everything has come back.
  localparam int SETTLE_CYCLES = 2 * (SEGMENTS + 64);
  // Cycles without any transfer or register write before the run is declared hung.
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 175;
  localparam int NUM_PHASES = 8;

  // The fourth action code has no meaning and must be ignored by the block.
  localparam logic [fdtd_ps_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // The pitch law works on d = note + 3, split into whole and sixth octaves.
  localparam int unsigned PITCH_BIAS = 3;
  localparam int unsigned SIXTHS = 6;
  localparam int unsigned PITCH_ALIGN = 28;
  localparam int unsigned SEMITONE_STEP [6] = '{65536, 73562, 82570, 92682, 104032, 116772};

  localparam longint AMP_MAX = 64'sd2147483647;
  localparam longint AMP_MIN = -64'sd2147483648;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [fdtd_ps_pkg::ACTION_W-1:0] action;
    logic [fdtd_ps_pkg::NOTE_W-1:0]   note_id;
  } note_event_t;

  typedef struct packed {
    logic [fdtd_ps_pkg::AMP_W-1:0] sample;
    logic                          note_held;
  } tone_sample_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [7:0]                         s_tdata = '0;    // [6:0] note_id
  logic [fdtd_ps_pkg::ACTION_W-1:0]   s_tuser = '0;    // [1:0] action
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [fdtd_ps_pkg::AMP_W-1:0]      m_tdata;         // [31:0] sample
  logic                               m_tuser;         // [0] note_held
  logic                               cfg_we = 1'b0;
  logic [fdtd_ps_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [fdtd_ps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  fdtd_plucked_string_top #(
    .STRING_SEGMENTS(SEGMENTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Behavioural string. The bench keeps its own copy of both displacement snapshots, the
  // squared Courant number, the note flags and the four registers, and advances them on
  // every input transfer exactly as the block is meant to.
  // ---------------------------------------------------------------------------------------
  int                             wave_now [SEGMENTS];
  int                             wave_prev [SEGMENTS];
  int unsigned                    wave_coef;       // squared Courant number, unsigned Q16.16
  bit                             note_active;
  bit                             note_released;
  logic [fdtd_ps_pkg::NOTE_W-1:0] active_note;

  logic [fdtd_ps_pkg::BASE_W-1:0]   base_coef;
  logic [fdtd_ps_pkg::PICK_W-1:0]   pick_reg;
  logic [fdtd_ps_pkg::HEIGHT_W-1:0] pluck_peak;
  logic [fdtd_ps_pkg::VOL_W-1:0]    out_gain;

  note_event_t  score [$];        // events waiting to be driven
  tone_sample_t due_samples [$];  // samples the block still owes us
  int           err_count = 0;

  function automatic void log_error(string what);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", what);
    end
  endfunction

  // The pick point is clamped away from the fixed ends, for the pluck and for the output.
  function automatic int pick_point();
    int p;
    p = pick_reg;
    if (p < 1) begin
      p = 1;
    end
    if (p > SEGMENTS - 2) begin
      p = SEGMENTS - 2;
    end
    return p;
  endfunction

  function automatic int clip_amp(longint v);
    if (v > AMP_MAX) begin
      return int'(AMP_MAX);
    end else if (v < AMP_MIN) begin
      return int'(AMP_MIN);
    end
    return int'(v);
  endfunction

  // Triangle rising from the left end to the peak at the pick point, then falling to zero
  // at the last moving point. Both snapshots start equal, so the string starts at rest.
  function automatic void pluck_shape();
    int   p;
    u64_t h;
    u64_t tail;
    p = pick_point();
    h = pluck_peak;
    tail = u64_t'(SEGMENTS - 1 - p);
    for (int x = 0; x < SEGMENTS; x++) begin
      if (x < p) begin
        wave_now[x] = int'((h * u64_t'(x)) / u64_t'(p));
      end else begin
        wave_now[x] = int'(h - (h * u64_t'(x - p)) / tail);
      end
      wave_prev[x] = wave_now[x];
    end
  endfunction

  // One explicit time step of the wave equation over the interior points. The point past
  // the end of the arrays is the fixed right end and reads as zero.
  function automatic void advance_wave();
    int     fresh [SEGMENTS];
    longint here;
    longint right;
    longint lap;
    longint bend;
    for (int x = 1; x < SEGMENTS; x++) begin
      here = wave_now[x];
      right = 0;
      if (x + 1 < SEGMENTS) begin
        right = wave_now[x + 1];
      end
      lap = longint'(wave_now[x - 1]) - 2 * here + right;
      bend = (longint'(wave_coef) * lap) >>> fdtd_ps_pkg::FRAC_W;
      fresh[x] = clip_amp(2 * here - longint'(wave_prev[x]) + bend);
    end
    for (int x = 1; x < SEGMENTS; x++) begin
      wave_prev[x] = wave_now[x];
      wave_now[x] = fresh[x];
    end
  endfunction

  function automatic void play_event(note_event_t ev);
    tone_sample_t due;
    int unsigned  d;
    u64_t         prod;
    case (ev.action)
      fdtd_ps_pkg::ACT_NOTE_ON: begin
        if (note_active) begin
          // A repeat strike never replucks: same note cancels a pending release,
          // another note only takes over the label.
          if (ev.note_id == active_note) begin
            note_released = 1'b0;
          end else begin
            active_note = ev.note_id;
          end
        end else begin
          d = ev.note_id + PITCH_BIAS;
          prod = u64_t'(base_coef) * SEMITONE_STEP[d % SIXTHS];
          wave_coef = 32'(prod >> (PITCH_ALIGN - d / SIXTHS));
          note_active = 1'b1;
          note_released = 1'b0;
          active_note = ev.note_id;
          pluck_shape();
        end
      end
      fdtd_ps_pkg::ACT_NOTE_OFF: begin
        if (note_active && ev.note_id == active_note) begin
          note_released = 1'b1;
        end
      end
      fdtd_ps_pkg::ACT_TICK: begin
        due.sample = '0;
        due.note_held = note_active;
        if (note_active) begin
          advance_wave();
          due.sample = clip_amp((longint'(out_gain) * longint'(wave_now[pick_point()]))
                                >>> fdtd_ps_pkg::FRAC_W);
          // A released note still sounds for this tick and is dropped afterwards.
          if (note_released) begin
            note_active = 1'b0;
            note_released = 1'b0;
          end
        end
        due_samples.insert(due_samples.size(), due);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  function automatic void queue_event(logic [fdtd_ps_pkg::ACTION_W-1:0] act,
                                      logic [fdtd_ps_pkg::NOTE_W-1:0] id);
    note_event_t ev;
    ev.action = act;
    ev.note_id = id;
    score.insert(score.size(), ev);
  endfunction

  // Random phrases: strike, let it ring, sometimes re-strike or hand the label to another
  // note, usually release and tick on past the drop. A note left ringing makes the next
  // phrase's strike a repeat. About one pick in ten is noise: the unused action, a stray
  // release or a lone tick. The note field of a tick carries random bits that must not
  // matter. Only items the block acts on count towards the target.
  function automatic void compose_phase(int target);
    int                             made;
    int                             ticks;
    logic [fdtd_ps_pkg::NOTE_W-1:0] tone;
    logic [fdtd_ps_pkg::NOTE_W-1:0] other;
    made = 0;
    while (made < target) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: queue_event(ACT_UNUSED, 7'($urandom));
          1: queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, 7'($urandom));
          default: begin
            queue_event(fdtd_ps_pkg::ACT_TICK, 7'($urandom));
            made++;
          end
        endcase
      end else begin
        tone = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(30, 100));
        queue_event(fdtd_ps_pkg::ACT_NOTE_ON, tone);
        ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        repeat (ticks) queue_event(fdtd_ps_pkg::ACT_TICK, 7'($urandom));
        made += 1 + ticks;
        case ($urandom_range(0, 5))
          0: begin
            other = 7'($urandom);
            queue_event(fdtd_ps_pkg::ACT_NOTE_ON, other);
            queue_event(fdtd_ps_pkg::ACT_TICK, 7'($urandom));
            tone = other;
            made += 2;
          end
          1: begin
            queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, tone);
            queue_event(fdtd_ps_pkg::ACT_NOTE_ON, tone);
            queue_event(fdtd_ps_pkg::ACT_TICK, 7'($urandom));
            made += 3;
          end
          default: ;
        endcase
        if ($urandom_range(0, 5) != 0) begin
          queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, tone);
          ticks = $urandom_range(1, 3);
          repeat (ticks) queue_event(fdtd_ps_pkg::ACT_TICK, 7'($urandom));
          made += 1 + ticks;
        end
      end
    end
  endfunction

  // Register writes are issued only while the block is idle, so the bench copy can take
  // the new value at once.
  task automatic write_reg(logic [fdtd_ps_pkg::CFG_IDX_W-1:0] idx,
                           logic [fdtd_ps_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fdtd_ps_pkg::REG_COURANT_BASE: base_coef = value[fdtd_ps_pkg::BASE_W-1:0];
      fdtd_ps_pkg::REG_PICK:         pick_reg = value[fdtd_ps_pkg::PICK_W-1:0];
      fdtd_ps_pkg::REG_HEIGHT:       pluck_peak = value[fdtd_ps_pkg::HEIGHT_W-1:0];
      fdtd_ps_pkg::REG_VOLUME:       out_gain = value[fdtd_ps_pkg::VOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_tuning(logic [fdtd_ps_pkg::CFG_DATA_W-1:0] base,
                            logic [fdtd_ps_pkg::CFG_DATA_W-1:0] pick,
                            logic [fdtd_ps_pkg::CFG_DATA_W-1:0] height,
                            logic [fdtd_ps_pkg::CFG_DATA_W-1:0] gain);
    write_reg(fdtd_ps_pkg::REG_COURANT_BASE, base);
    write_reg(fdtd_ps_pkg::REG_PICK, pick);
    write_reg(fdtd_ps_pkg::REG_HEIGHT, height);
    write_reg(fdtd_ps_pkg::REG_VOLUME, gain);
  endtask

  // Waits until every event has been driven and every owed sample has arrived, sampling
  // on the falling edge so that the driver's and monitor's updates have all landed, then
  // lets a possible note-on sweep run out.
  task automatic settle();
    while (score.size() != 0 || s_tvalid || due_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: sends the queued events in bursts of random length separated by random gaps,
  // with some bursts running straight into the next. Each accepted transfer is fed to the
  // behavioural string on the edge at which it is taken.
  // ---------------------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    note_event_t taken;
    note_event_t next_ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        taken.action = s_tuser;
        taken.note_id = s_tdata[fdtd_ps_pkg::NOTE_W-1:0];
        play_event(taken);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (score.size() > 0) begin
          next_ev = score.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, next_ev.note_id};
          s_tuser <= next_ev.action;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest owed sample. Its ready line
  // follows a pattern of its own that changes at random intervals between always
  // ready, light, heavy and very heavy back-pressure.
  // ---------------------------------------------------------------------------------------
  int ready_odds = 8;
  int pattern_left = 0;

  always @(posedge clk) begin
    tone_sample_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (due_samples.size() == 0) begin
        log_error($sformatf("unexpected sample transfer: sample %0d note_held %0b",
                            $signed(m_tdata), m_tuser));
      end else begin
        due = due_samples.pop_front();
        if (m_tdata !== due.sample || m_tuser !== due.note_held) begin
          log_error($sformatf("sample mismatch: expected %0d/%0b, got %0d/%0b",
                              $signed(due.sample), due.note_held, $signed(m_tdata), m_tuser));
        end
      end
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(50, 400);
      case ($urandom_range(0, 3))
        0: ready_odds = 8;
        1: ready_odds = 6;
        2: ready_odds = 3;
        default: ready_odds = 1;
      endcase
    end else begin
      pattern_left--;
    end
    m_tready <= ($urandom_range(0, 7) < ready_odds);
  end

  // Watchdog: any transfer or register write counts as progress.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence: reset, a directed opening at the reset tuning, then random phases, each
  // under a new tuning written while the block is idle.
  // ---------------------------------------------------------------------------------------
  initial begin
    base_coef = 18'd4096;
    pick_reg = 6'd31;
    pluck_peak = 30'd268435456;
    out_gain = 18'd65536;
    wave_coef = 0;
    note_active = 1'b0;
    note_released = 1'b0;
    active_note = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Nothing held: a silent tick, a stray release and the unused action.
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, 7'd69);
    queue_event(ACT_UNUSED, 7'd127);
    // Reference pitch, then a repeat strike on the same note and a relabel to another.
    queue_event(fdtd_ps_pkg::ACT_NOTE_ON, 7'd69);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd127);
    queue_event(fdtd_ps_pkg::ACT_NOTE_ON, 7'd69);
    queue_event(fdtd_ps_pkg::ACT_NOTE_ON, 7'd72);
    // The old label no longer releases anything.
    queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, 7'd69);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    // Release followed by a re-strike of the same note keeps it sounding.
    queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, 7'd72);
    queue_event(fdtd_ps_pkg::ACT_NOTE_ON, 7'd72);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    // A real release: it still sounds for one tick, then the string is silent.
    queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, 7'd72);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    // Highest note, far beyond the stable Courant limit, so the points saturate.
    queue_event(fdtd_ps_pkg::ACT_NOTE_ON, 7'd127);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, 7'd127);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    // Lowest note: the Courant number rounds down to almost nothing.
    queue_event(fdtd_ps_pkg::ACT_NOTE_ON, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_NOTE_OFF, 7'd0);
    queue_event(fdtd_ps_pkg::ACT_TICK, 7'd0);
    settle();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        // Every other register at its top; the pick below range clamps to point 1.
        1: set_tuning(30'h3FFFF, 30'd0, 30'h3FFF_FFFF, 30'h3FFFF);
        // Every other register at zero; the pick above range clamps to the last but one point.
        2: set_tuning(30'd0, 30'd63, 30'd0, 30'd0);
        3: set_tuning(30'd4096, 30'd1, 30'h3FFF_FFFF, 30'd65536);
        4: set_tuning(30'd16384, 30'd62, 30'd268435456, 30'd131072);
        // Full-width random data: bits above a register's width must be dropped.
        5: set_tuning(30'($urandom), 30'($urandom), 30'($urandom), 30'($urandom));
        default: set_tuning(30'($urandom_range(0, 20000)), 30'($urandom_range(1, 62)),
                            30'($urandom), 30'($urandom_range(0, 262143)));
      endcase
      compose_phase(PHASE_ITEMS);
      settle();
    end

    if (err_count == 0 && due_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fdtd_ps_pkg.sv
rtl/fdtd_ps_divider.sv
rtl/fdtd_ps_amp_mem.sv
rtl/fdtd_ps_core.sv
rtl/fdtd_plucked_string_top.sv
tb/sv/tb_fdtd_plucked_string_top.sv
